FILE: rtl/nearest_key_time_lookup_macros.svh
// ----------------------------------------------------------------------------
// nearest_key_time_lookup assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_KEY_TIME_LOOKUP_MACROS_SVH
`define NEAREST_KEY_TIME_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NKTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nktl assertion failed");
// next-cycle implication
`define NKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nktl assertion failed");
`else
`define NKTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/nktl_pkg.sv
// ----------------------------------------------------------------------------
// nktl_pkg
// Shared constants, codes and payload types of the nearest-key time lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nktl_pkg;

    localparam int TABLE_DEPTH    = 128;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int WRITABLE_SLOTS = 128;
    localparam int SLOT_CAP       = (TABLE_DEPTH < WRITABLE_SLOTS) ? TABLE_DEPTH
                                                                   : WRITABLE_SLOTS;
    localparam int PERCENT_SLOTS  = 100;

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 48;
    localparam int SLOT_W  = 7;
    localparam int CNT_W   = 8;
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_KEYED_MODE  = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PCT   = 2'd1;
    localparam logic [1:0] OP_KEYED = 2'd2;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] entry_index;
        logic [KEY_W-1:0]  entry_key;
        logic [TIME_W-1:0] entry_time;
        logic [KEY_W-1:0]  query_events;
        logic [SLOT_W-1:0] random_percent;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] latency;
        logic [SLOT_W-1:0] chosen_slot;
        logic              exact_hit;
    } result_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] tval;
        logic [KEY_W-1:0]  query;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: rtl/nktl_ram.sv
// ----------------------------------------------------------------------------
// nktl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nktl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/nktl_front.sv
// ----------------------------------------------------------------------------
// nktl_front
// Accepts input transactions, classifies them into jobs and feeds the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nktl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  nktl_pkg::item_t item,
    input  logic            keyed_mode,
    input  nktl_pkg::qstat_t qstat,
    output logic            push,
    output nktl_pkg::job_t  job
);

    import nktl_pkg::*;

    logic              stage_valid_reg;
    logic              stage_valid_next;
    job_t              stage_reg;
    job_t              stage_next;
    job_t              job_in;
    logic [SLOT_W-1:0] pct_slot;
    logic              accept;

    assign push       = stage_valid_reg && !qstat.full;
    assign item_ready = !stage_valid_reg || push;
    assign accept     = item_valid && item_ready;
    assign job        = stage_reg;

    always_comb
    begin
        if (item.random_percent >= SLOT_W'(PERCENT_SLOTS))
        begin
            pct_slot = item.random_percent - SLOT_W'(PERCENT_SLOTS);
        end
        else
        begin
            pct_slot = item.random_percent;
        end

        job_in.key   = item.entry_key;
        job_in.tval  = item.entry_time;
        job_in.query = item.query_events;
        if (item.command == CMD_WRITE)
        begin
            job_in.op   = OP_WRITE;
            job_in.slot = item.entry_index;
        end
        else if (keyed_mode)
        begin
            job_in.op   = OP_KEYED;
            job_in.slot = item.entry_index;
        end
        else
        begin
            job_in.op   = OP_PCT;
            job_in.slot = pct_slot;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_next       = job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

FILE: rtl/nktl_queue.sv
// ----------------------------------------------------------------------------
// nktl_queue
// Short job FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nktl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nktl_pkg::job_t   push_job,
    input  logic             pop,
    output nktl_pkg::job_t   head,
    output nktl_pkg::qstat_t qstat
);

    import nktl_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/nktl_back.sv
// ----------------------------------------------------------------------------
// nktl_back
// Executes jobs: table writes, percentile reads and the nearest-key scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nktl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nktl_pkg::CNT_W-1:0]    entry_count,
    input  nktl_pkg::job_t                head,
    input  nktl_pkg::qstat_t              qstat,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output nktl_pkg::result_t             result
);

    import nktl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  iss_reg;
    logic [CNT_W-1:0]  iss_next;
    logic              chk_vld_reg;
    logic              chk_vld_next;
    logic [CNT_W-1:0]  chk_idx_reg;
    logic [CNT_W-1:0]  chk_idx_next;
    logic              gt_found_reg;
    logic              gt_found_next;
    logic [CNT_W-1:0]  gt_idx_reg;
    logic [CNT_W-1:0]  gt_idx_next;
    logic [KEY_W-1:0]  prev_key_reg;
    logic [KEY_W-1:0]  prev_key_next;
    logic [KEY_W-1:0]  up_diff_reg;
    logic [KEY_W-1:0]  up_diff_next;
    logic [KEY_W-1:0]  lo_diff_reg;
    logic [KEY_W-1:0]  lo_diff_next;
    logic [KEY_W-1:0]  query_reg;
    logic [KEY_W-1:0]  query_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              hit_reg;
    logic              hit_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           out_next;

    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W-1:0]  gt_prev;
    logic              out_free;
    logic              wr_ok;
    logic              table_we;
    logic [ADDR_W-1:0] key_raddr;
    logic [ADDR_W-1:0] time_raddr;
    logic [KEY_W-1:0]  key_rdata;
    logic [TIME_W-1:0] time_rdata;

    always_comb
    begin
        if (entry_count == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (entry_count > CNT_W'(SLOT_CAP))
        begin
            n_eff = CNT_W'(SLOT_CAP);
        end
        else
        begin
            n_eff = entry_count;
        end
    end

    assign last_idx     = n_eff - CNT_W'(1);
    assign gt_prev      = gt_idx_reg - CNT_W'(1);
    assign out_free     = !out_valid_reg || result_ready;
    assign pop          = (state_reg == ST_IDLE) && !qstat.empty && out_free;
    assign wr_ok        = int'(head.slot) < TABLE_DEPTH;
    assign table_we     = pop && (head.op == OP_WRITE) && wr_ok;
    assign key_raddr    = ADDR_W'(iss_reg);
    assign time_raddr   = (state_reg == ST_IDLE) ? ADDR_W'(head.slot) : ADDR_W'(slot_reg);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    nktl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (table_we),
        .waddr (ADDR_W'(head.slot)),
        .wdata (head.key),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    nktl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (table_we),
        .waddr (ADDR_W'(head.slot)),
        .wdata (head.tval),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        gt_found_next  = gt_found_reg;
        gt_idx_next    = gt_idx_reg;
        prev_key_next  = prev_key_reg;
        up_diff_next   = up_diff_reg;
        lo_diff_next   = lo_diff_reg;
        query_next     = query_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.op)
                        OP_WRITE:
                        begin
                            out_next.latency     = '0;
                            out_next.chosen_slot = head.slot;
                            out_next.exact_hit   = 1'b0;
                            out_valid_next       = 1'b1;
                        end
                        OP_PCT:
                        begin
                            slot_next  = head.slot;
                            hit_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        OP_KEYED:
                        begin
                            query_next    = head.query;
                            iss_next      = '0;
                            chk_vld_next  = 1'b0;
                            gt_found_next = 1'b0;
                            prev_key_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                chk_vld_next = (iss_reg < n_eff);
                chk_idx_next = iss_reg;
                if (iss_reg < n_eff)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (key_rdata == query_reg)
                    begin
                        hit_next   = 1'b1;
                        slot_next  = chk_idx_reg[SLOT_W-1:0];
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        if (!gt_found_reg && (key_rdata > query_reg))
                        begin
                            gt_found_next = 1'b1;
                            gt_idx_next   = chk_idx_reg;
                            up_diff_next  = key_rdata - query_reg;
                            lo_diff_next  = query_reg - prev_key_reg;
                        end
                        prev_key_next = key_rdata;
                        if (chk_idx_reg == last_idx)
                        begin
                            state_next = ST_PICK;
                        end
                    end
                end
            end
            ST_PICK:
            begin
                hit_next = 1'b0;
                if (!gt_found_reg)
                begin
                    slot_next = last_idx[SLOT_W-1:0];
                end
                else if (gt_idx_reg == '0)
                begin
                    slot_next = '0;
                end
                else if (up_diff_reg < lo_diff_reg)
                begin
                    slot_next = gt_idx_reg[SLOT_W-1:0];
                end
                else
                begin
                    slot_next = gt_prev[SLOT_W-1:0];
                end
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_next.latency     = time_rdata;
                out_next.chosen_slot = slot_reg;
                out_next.exact_hit   = hit_reg;
                out_valid_next       = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        gt_found_reg <= gt_found_next;
        gt_idx_reg   <= gt_idx_next;
        prev_key_reg <= prev_key_next;
        up_diff_reg  <= up_diff_next;
        lo_diff_reg  <= lo_diff_next;
        query_reg    <= query_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        out_reg      <= out_next;
    end

endmodule

FILE: rtl/nearest_key_time_lookup.sv
// Input transaction to result: front stage register, queue, then in the back ST_IDLE for
// a write, ST_IDLE and ST_DONE for a percentile query, and for a keyed query ST_SCAN over
// up to n keys (n = effective entry count), ST_PICK unless an exact hit ends the scan,
// ST_FETCH and ST_DONE. One job runs in the back at a time; keyed throughput is set by
// the key memory scan, one key per cycle over the read port. With the receiver ready the
// back takes a new write job every cycle. A two-entry queue decouples the front. Reset
// clears control state, keyed_mode to 0 and entry_count to 1; table is unset.
// ----------------------------------------------------------------------------
// nearest_key_time_lookup
// Latency table with nearest-key and percentile lookup, APB configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nearest_key_time_lookup_macros.svh"

module nearest_key_time_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  nktl_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output nktl_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nktl_pkg::PADDR_W-1:0]  paddr,
    input  logic [nktl_pkg::DATA_W-1:0]   pwdata,
    output logic [nktl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import nktl_pkg::*;

    logic             keyed_mode_reg;
    logic             keyed_mode_next;
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic             cfg_we;
    logic             push;
    logic             pop;
    job_t             push_job;
    job_t             head;
    qstat_t           qstat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        keyed_mode_next  = keyed_mode_reg;
        entry_count_next = entry_count_reg;
        if (cfg_we)
        begin
            case (paddr[2])
                REG_KEYED_MODE:  keyed_mode_next  = pwdata[0];
                REG_ENTRY_COUNT: entry_count_next = pwdata[CNT_W-1:0];
                default:         keyed_mode_next  = keyed_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_KEYED_MODE:  prdata = {{(DATA_W-1){1'b0}}, keyed_mode_reg};
            REG_ENTRY_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, entry_count_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyed_mode_reg  <= 1'b0;
            entry_count_reg <= CNT_W'(1);
        end
        else
        begin
            keyed_mode_reg  <= keyed_mode_next;
            entry_count_reg <= entry_count_next;
        end
    end

    nktl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .keyed_mode (keyed_mode_reg),
        .qstat      (qstat),
        .push       (push),
        .job        (push_job)
    );

    nktl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    nktl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_count  (entry_count_reg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `NKTL_ASSERT_IMPLY(a_hit_needs_keyed, clk, rst_n, result_valid && result.exact_hit, keyed_mode_reg)
    `NKTL_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, pop, !qstat.empty)
    `NKTL_ASSERT_IMPLY(a_push_not_full, clk, rst_n, push, !qstat.full)
    `NKTL_ASSERT_NEXT(a_write_ack, clk, rst_n, pop && (head.op == OP_WRITE), result_valid)

endmodule

FILE: tb/nearest_key_time_lookup_tb.sv
// ----------------------------------------------------------------------------
// nearest_key_time_lookup_tb
// Self-checking bench for the nearest-key latency table. Table writes,
// percentile queries and nearest-key queries go in over valid/ready, and
// the mode and entry count are set over APB while the block is idle. A
// local model of the table predicts every result, and a monitor compares
// each accepted result field by field. Directed edge cases are followed
// by random phases with sorted tables, noise and varying idle on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_key_time_lookup_tb;

    import nktl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_t               item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [KEY_W-1:0]    key_tbl [TABLE_DEPTH];
    logic [TIME_W-1:0]   time_tbl [TABLE_DEPTH];
    logic                keyed_q = 1'b0;
    logic [CNT_W-1:0]    count_q = 8'd1;

    result_t             pending_lookups [$];
    result_t             want;
    int unsigned         items_sent = 0;
    int unsigned         mismatches = 0;
    int unsigned         cycles = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct = 0;
    int unsigned         hold_requests = 0;
    int unsigned         hold_served = 0;
    int unsigned         hold_left = 0;

    nearest_key_time_lookup uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hold off the receiver for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (result.latency !== want.latency)
                begin
                    mismatches++;
                    $display("%0t: latency mismatch, expected %h, actual %h",
                             $time, want.latency, result.latency);
                end
                if (result.chosen_slot !== want.chosen_slot)
                begin
                    mismatches++;
                    $display("%0t: chosen_slot mismatch, expected %0d, actual %0d",
                             $time, want.chosen_slot, result.chosen_slot);
                end
                if (result.exact_hit !== want.exact_hit)
                begin
                    mismatches++;
                    $display("%0t: exact_hit mismatch, expected %b, actual %b",
                             $time, want.exact_hit, result.exact_hit);
                end
            end
        end
    end

    function automatic result_t lookup_latency(input item_t it);
        result_t           r;
        int                n;
        int                i;
        int                slot;
        logic [KEY_W-1:0]  q;
        logic [KEY_W-1:0]  du;
        logic [KEY_W-1:0]  dl;
        r = '0;
        q = it.query_events;
        if (it.command == CMD_WRITE)
        begin
            key_tbl[it.entry_index]  = it.entry_key;
            time_tbl[it.entry_index] = it.entry_time;
            r.chosen_slot = it.entry_index;
            return r;
        end
        if (!keyed_q)
        begin
            slot = int'(it.random_percent) % PERCENT_SLOTS;
        end
        else
        begin
            n = (count_q == 0) ? 1 : int'(count_q);
            if (n > SLOT_CAP)
                n = SLOT_CAP;
            slot = -1;
            for (i = 0; i < n; i++)
            begin
                if (slot < 0 && key_tbl[i] == q)
                    slot = i;
            end
            if (slot >= 0)
            begin
                r.exact_hit = 1'b1;
            end
            else
            begin
                i = 0;
                while (i < n && key_tbl[i] <= q)
                    i++;
                if (i == 0)
                    slot = 0;
                else if (i >= n)
                    slot = n - 1;
                else
                begin
                    du = key_tbl[i] - q;
                    dl = q - key_tbl[i-1];
                    slot = (du < dl) ? i : i - 1;
                end
            end
        end
        r.latency     = time_tbl[slot];
        r.chosen_slot = SLOT_W'(slot);
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic item_t write_item(input int slot, input logic [KEY_W-1:0] key,
                                         input logic [TIME_W-1:0] tval);
        item_t it;
        it.command        = CMD_WRITE;
        it.entry_index    = SLOT_W'(slot);
        it.entry_key      = key;
        it.entry_time     = tval;
        it.query_events   = $urandom;
        it.random_percent = SLOT_W'($urandom);
        return it;
    endfunction

    function automatic item_t query_item(input logic [KEY_W-1:0] q, input int pct);
        item_t it;
        it.command        = CMD_QUERY;
        it.entry_index    = SLOT_W'($urandom);
        it.entry_key      = $urandom;
        it.entry_time     = rand_time();
        it.query_events   = q;
        it.random_percent = SLOT_W'(pct);
        return it;
    endfunction

    // pick a query near the first n keys: exact, off by a little, midpoint, extremes
    function automatic logic [KEY_W-1:0] near_query(input int n);
        int               j;
        logic [KEY_W-1:0] k;
        j = $urandom_range(n - 1, 0);
        k = key_tbl[j];
        case ($urandom_range(6, 0))
            0: return k;
            1: return k + $urandom_range(3, 1);
            2: return k - $urandom_range(3, 1);
            3: return (j < n - 1) ? k + (key_tbl[j+1] - k) / 2 : k;
            4: return '0;
            5: return '1;
            default: return $urandom;
        endcase
    endfunction

    // call at a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input item_t it);
        int   gap;
        logic taken;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = item_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_lookups.insert(pending_lookups.size(), lookup_latency(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic sel, input logic [DATA_W-1:0] value);
        logic done;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(sel));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_KEYED_MODE)
            keyed_q = value[0];
        else
            count_q = value[CNT_W-1:0];
    endtask

    task automatic load_sorted(input int n, input bit tight);
        longint unsigned key;
        longint unsigned step_max;
        int              i;
        step_max = tight ? 4 : (64'hFFFF_FFFF / (n + 1));
        key = $urandom_range(int'(step_max), 0);
        for (i = 0; i < n; i++)
        begin
            send_item(write_item(i, key[KEY_W-1:0], rand_time()));
            key += $urandom_range(int'(step_max), 1);
        end
    endtask

    task automatic test_fill_table();
        load_sorted(TABLE_DEPTH, 1'b0);
    endtask

    task automatic test_percentile_mode();
        send_item(query_item($urandom, 0));
        send_item(query_item($urandom, 99));
        send_item(query_item($urandom, 100));
        send_item(query_item($urandom, 127));
        send_item(query_item($urandom, 50));
    endtask

    task automatic test_keyed_extremes();
        logic [KEY_W-1:0] mid;
        send_item(write_item(0, '0, '0));
        send_item(write_item(TABLE_DEPTH - 1, '1, '1));
        write_register(REG_KEYED_MODE, 1);
        write_register(REG_ENTRY_COUNT, SLOT_CAP);
        send_item(query_item('0, $urandom));
        send_item(query_item('1, $urandom));
        send_item(query_item(key_tbl[64], $urandom));
        send_item(query_item(key_tbl[64] + 1, $urandom));
        mid = key_tbl[10] + (key_tbl[11] - key_tbl[10]) / 2;
        send_item(query_item(mid, $urandom));
        send_item(query_item(mid + 1, $urandom));
    endtask

    task automatic test_entry_count_limits();
        write_register(REG_ENTRY_COUNT, 0);
        send_item(query_item($urandom, $urandom));
        write_register(REG_ENTRY_COUNT, 255);
        send_item(query_item(32'hFFFF_FFF0, $urandom));
        write_register(REG_ENTRY_COUNT, 3);
        send_item(query_item(key_tbl[2] + 100, $urandom));
    endtask

    task automatic test_duplicate_unsorted();
        send_item(write_item(0, 1000, rand_time()));
        send_item(write_item(1, 1000, rand_time()));
        send_item(write_item(2, 500, rand_time()));
        send_item(write_item(3, 3000, rand_time()));
        write_register(REG_ENTRY_COUNT, 4);
        send_item(query_item(1000, $urandom));
        send_item(query_item(500, $urandom));
        send_item(query_item(10, $urandom));
        send_item(query_item(2000, $urandom));
        send_item(query_item(4000, $urandom));
    endtask

    task automatic test_backpressure();
        int i;
        write_register(REG_KEYED_MODE, 0);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        for (i = 0; i < 24; i++)
        begin
            if (i % 4 == 3)
                send_item(write_item($urandom_range(127, 100), $urandom, rand_time()));
            else
                send_item(query_item($urandom, $urandom));
        end
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        int unsigned target;
        int          n;
        int          r;
        target        = items_sent + count;
        send_idle_pct = idle;
        stall_pct     = stall;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                r = $urandom_range(99);
                if (r < 85)
                    n = $urandom_range(12, 1);
                else if (r < 97)
                    n = $urandom_range(64, 13);
                else
                    n = SLOT_CAP;
                load_sorted(n, $urandom_range(2, 0) == 0);
                if (n == 1 && $urandom_range(1, 0))
                    write_register(REG_ENTRY_COUNT, 0);
                else if (n == SLOT_CAP && $urandom_range(1, 0))
                    write_register(REG_ENTRY_COUNT, $urandom_range(255, SLOT_CAP + 1));
                else
                    write_register(REG_ENTRY_COUNT, n);
                write_register(REG_KEYED_MODE, $urandom_range(3, 0) != 0);
                repeat ($urandom_range(16, 4))
                    send_item(query_item(near_query(n), $urandom));
            end
            else
            begin
                repeat ($urandom_range(8, 2))
                begin
                    if ($urandom_range(1, 0))
                        send_item(write_item($urandom_range(127, 0), $urandom, rand_time()));
                    else if ($urandom_range(1, 0))
                        send_item(query_item($urandom, $urandom));
                    else
                        send_item(query_item(key_tbl[$urandom_range(127, 0)], $urandom));
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_table();
        test_percentile_mode();
        test_keyed_extremes();
        test_entry_count_limits();
        test_duplicate_unsorted();
        test_backpressure();
        test_random_phase(0, 0, 185);
        test_random_phase(79, 0, 185);
        test_random_phase(0, 79, 185);
        test_random_phase(10, 10, 185);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
